// ===== design/ota_image_stream_deframer_top_defines.svh =====
// Assertion macros shared by the deframer checker.
// No dependencies; expects signals named clock and reset in the using scope.
`ifndef OTA_IMAGE_STREAM_DEFRAMER_TOP_DEFINES_SVH
`define OTA_IMAGE_STREAM_DEFRAMER_TOP_DEFINES_SVH

// Property checked outside reset
`define OTADF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every edge, reset included
`define OTADF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/otadf_pkg.sv =====
// Shared types and constants for the upgrade image stream deframer.
// No dependencies; used by every module of the block.
package otadf_pkg;

   // Header geometry
   localparam int MAND_HDR_BYTES = 56;
   localparam int ELEM_HDR_BYTES = 6;

   // Byte offsets inside the mandatory header (little endian fields)
   localparam logic [31:0] OFS_HDR_LEN_LO = 32'd6;
   localparam logic [31:0] OFS_HDR_LEN_HI = 32'd7;
   localparam logic [31:0] OFS_FC_LO      = 32'd8;
   localparam logic [31:0] OFS_FC_HI      = 32'd9;

   // Byte offsets inside an element header
   localparam logic [31:0] OFS_TAG_LO = 32'd0;
   localparam logic [31:0] OFS_TAG_HI = 32'd1;
   localparam logic [31:0] OFS_LEN_B0 = 32'd2;
   localparam logic [31:0] OFS_LEN_B1 = 32'd3;
   localparam logic [31:0] OFS_LEN_B2 = 32'd4;
   localparam logic [31:0] OFS_LEN_B3 = 32'd5;

   // Field-control bits
   localparam int FC_CRED = 0;
   localparam int FC_DEST = 1;
   localparam int FC_HW   = 2;
   localparam logic [3:0] DEST_BYTES = 4'd8;

   // Parser phase, also the reported section code
   typedef enum logic [1:0] {
      PH_MAND = 2'd0,
      PH_OPT  = 2'd1,
      PH_EHDR = 2'd2,
      PH_PAY  = 2'd3
   } phase_type;

   // Result tdata layout, lowest field last; 99 bits used, padded to 104
   typedef struct packed {
      logic [4:0]  pad;
      logic        overrun;
      logic        image_complete;
      logic [15:0] max_hw_version;
      logic [15:0] min_hw_version;
      logic [7:0]  credential_version;
      logic [15:0] field_control;
      logic [15:0] header_length;
      logic        header_done;
      logic [15:0] element_tag;
      logic [7:0]  payload_byte;
   } rsp_data_type;

   localparam int RSP_DATA_W = $bits(rsp_data_type);

   // One result transaction between parser and output stage
   typedef struct packed {
      phase_type    section;
      logic         element_last;
      rsp_data_type data;
   } result_type;

endpackage

// ===== design/otadf_parse.sv =====
// Per-byte parser state and result logic for the deframer.
// Depends on otadf_pkg.
module otadf_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 start_image,
   input  logic [31:0]          image_size,
   output otadf_pkg::result_type result
);

   // State registers
   otadf_pkg::phase_type phase_ff, phase_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [31:0] offset_ff, offset_in;
   logic [15:0] hdr_len_ff, hdr_len_in;
   logic [15:0] fc_ff, fc_in;
   logic [7:0]  cred_ff, cred_in;
   logic [15:0] hw_min_ff, hw_min_in;
   logic [15:0] hw_max_ff, hw_max_in;
   logic [15:0] tag_ff, tag_in;
   logic [31:0] elem_len_ff, elem_len_in;
   logic        done_ff, done_in;

   // State as seen by this byte, after an image restart
   otadf_pkg::phase_type phase_cur;
   logic [31:0] bytes_cur, offset_cur, elem_len_cur;
   logic [15:0] hdr_len_cur, fc_cur, hw_min_cur, hw_max_cur, tag_cur;
   logic [7:0]  cred_cur;
   logic        done_cur;

   logic [32:0] offset_inc;
   logic        mand_end, opt_end, ehdr_end, pay_end;
   logic [15:0] opt_len;
   logic [3:0]  opt_at;
   logic        last;

   assign phase_cur    = start_image ? otadf_pkg::PH_MAND : phase_ff;
   assign bytes_cur    = start_image ? '0 : bytes_ff;
   assign offset_cur   = start_image ? '0 : offset_ff;
   assign hdr_len_cur  = start_image ? '0 : hdr_len_ff;
   assign fc_cur       = start_image ? '0 : fc_ff;
   assign cred_cur     = start_image ? '0 : cred_ff;
   assign hw_min_cur   = start_image ? '0 : hw_min_ff;
   assign hw_max_cur   = start_image ? '0 : hw_max_ff;
   assign tag_cur      = start_image ? '0 : tag_ff;
   assign elem_len_cur = start_image ? '0 : elem_len_ff;
   assign done_cur     = start_image ? 1'b0 : done_ff;

   // Saturating byte count
   assign bytes_in = (bytes_cur == '1) ? bytes_cur : bytes_cur + 32'd1;

   // Section boundary tests
   assign offset_inc = {1'b0, offset_cur} + 33'd1;
   assign opt_len    = hdr_len_cur - 16'(otadf_pkg::MAND_HDR_BYTES);
   assign mand_end   = offset_inc >= 33'(otadf_pkg::MAND_HDR_BYTES);
   assign opt_end    = offset_inc >= {17'b0, opt_len};
   assign ehdr_end   = offset_inc >= 33'(otadf_pkg::ELEM_HDR_BYTES);
   assign pay_end    = offset_inc >= {1'b0, elem_len_cur};

   // Start of the hardware version pair inside the optional header
   assign opt_at = {3'b0, fc_cur[otadf_pkg::FC_CRED]}
                 + (fc_cur[otadf_pkg::FC_DEST] ? otadf_pkg::DEST_BYTES : 4'd0);

   // Next phase
   always_comb begin
      phase_in = phase_cur;
      case (phase_cur)
         otadf_pkg::PH_MAND: begin
            if (mand_end) begin
               phase_in = (hdr_len_in > 16'(otadf_pkg::MAND_HDR_BYTES)) ?
                          otadf_pkg::PH_OPT : otadf_pkg::PH_EHDR;
            end
         end
         otadf_pkg::PH_OPT: begin
            if (opt_end) phase_in = otadf_pkg::PH_EHDR;
         end
         otadf_pkg::PH_EHDR: begin
            if (ehdr_end && (elem_len_in != '0)) phase_in = otadf_pkg::PH_PAY;
         end
         otadf_pkg::PH_PAY: begin
            if (pay_end) phase_in = otadf_pkg::PH_EHDR;
         end
         default: phase_in = otadf_pkg::PH_MAND;
      endcase
   end

   // Field capture, offset and end-of-element flag
   always_comb begin
      offset_in   = offset_inc[31:0];
      hdr_len_in  = hdr_len_cur;
      fc_in       = fc_cur;
      cred_in     = cred_cur;
      hw_min_in   = hw_min_cur;
      hw_max_in   = hw_max_cur;
      tag_in      = tag_cur;
      elem_len_in = elem_len_cur;
      done_in     = done_cur;
      last        = 1'b0;
      case (phase_cur)
         otadf_pkg::PH_MAND: begin
            case (offset_cur)
               otadf_pkg::OFS_HDR_LEN_LO: hdr_len_in[7:0]  = data_byte;
               otadf_pkg::OFS_HDR_LEN_HI: hdr_len_in[15:8] = data_byte;
               otadf_pkg::OFS_FC_LO:      fc_in[7:0]       = data_byte;
               otadf_pkg::OFS_FC_HI:      fc_in[15:8]      = data_byte;
               default: ;
            endcase
            if (mand_end) begin
               offset_in = '0;
               if (hdr_len_in <= 16'(otadf_pkg::MAND_HDR_BYTES)) done_in = 1'b1;
            end
         end
         otadf_pkg::PH_OPT: begin
            if (fc_cur[otadf_pkg::FC_CRED] && (offset_cur == '0)) cred_in = data_byte;
            if (fc_cur[otadf_pkg::FC_HW]) begin
               if (offset_cur == 32'(opt_at))              hw_min_in[7:0]  = data_byte;
               else if (offset_cur == 32'(opt_at) + 32'd1) hw_min_in[15:8] = data_byte;
               else if (offset_cur == 32'(opt_at) + 32'd2) hw_max_in[7:0]  = data_byte;
               else if (offset_cur == 32'(opt_at) + 32'd3) hw_max_in[15:8] = data_byte;
            end
            if (opt_end) begin
               offset_in = '0;
               done_in   = 1'b1;
            end
         end
         otadf_pkg::PH_EHDR: begin
            case (offset_cur)
               otadf_pkg::OFS_TAG_LO: tag_in = {8'b0, data_byte};
               otadf_pkg::OFS_TAG_HI: tag_in = tag_cur | {data_byte, 8'b0};
               otadf_pkg::OFS_LEN_B0: elem_len_in = {24'b0, data_byte};
               otadf_pkg::OFS_LEN_B1: elem_len_in = elem_len_cur | {16'b0, data_byte, 8'b0};
               otadf_pkg::OFS_LEN_B2: elem_len_in = elem_len_cur | {8'b0, data_byte, 16'b0};
               otadf_pkg::OFS_LEN_B3: elem_len_in = elem_len_cur | {data_byte, 24'b0};
               default: ;
            endcase
            if (ehdr_end) begin
               offset_in = '0;
               // zero-length element ends on its own header
               if (elem_len_in == '0) last = 1'b1;
            end
         end
         otadf_pkg::PH_PAY: begin
            if (pay_end) begin
               offset_in = '0;
               last      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Result for this byte
   always_comb begin
      result                         = '0;
      result.section                 = phase_cur;
      result.element_last            = last;
      result.data.payload_byte       = data_byte;
      result.data.element_tag        = tag_in;
      result.data.header_done        = done_in;
      result.data.header_length      = hdr_len_in;
      result.data.field_control      = fc_in;
      result.data.credential_version = cred_in;
      result.data.min_hw_version     = hw_min_in;
      result.data.max_hw_version     = hw_max_in;
      result.data.image_complete     = (image_size != '0) && (bytes_in == image_size);
      result.data.overrun            = (image_size != '0) && (bytes_in > image_size);
   end

   // State update on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= otadf_pkg::PH_MAND;
         bytes_ff    <= '0;
         offset_ff   <= '0;
         hdr_len_ff  <= '0;
         fc_ff       <= '0;
         cred_ff     <= '0;
         hw_min_ff   <= '0;
         hw_max_ff   <= '0;
         tag_ff      <= '0;
         elem_len_ff <= '0;
         done_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         bytes_ff    <= bytes_in;
         offset_ff   <= offset_in;
         hdr_len_ff  <= hdr_len_in;
         fc_ff       <= fc_in;
         cred_ff     <= cred_in;
         hw_min_ff   <= hw_min_in;
         hw_max_ff   <= hw_max_in;
         tag_ff      <= tag_in;
         elem_len_ff <= elem_len_in;
         done_ff     <= done_in;
      end
   end

endmodule

// ===== design/otadf_outreg.sv =====
// Result register of the deframer: holds one result transaction for the sink.
// Depends on otadf_pkg.
module otadf_outreg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  otadf_pkg::result_type             result,
   output logic                              free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [otadf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast
);

   logic                  valid_ff;
   otadf_pkg::result_type data_ff;

   // Register is free when empty or being drained this cycle
   assign free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load) data_ff <= result;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff.data;
   assign rsp_tuser  = data_ff.section;
   assign rsp_tlast  = data_ff.element_last;

endmodule

// ===== design/ota_image_stream_deframer_top.sv =====
// Top level of the upgrade image stream deframer.
// Depends on otadf_pkg, otadf_parse and otadf_outreg.
//
// Takes one image byte per cycle while the sink keeps reading, and returns
// one result per byte from the output register, loaded on acceptance; a
// byte is accepted whenever that register is empty or being read. The
// parser state updates in the accepting cycle, so the rate is set by the
// combinational field capture and the 32-bit byte-count compare.
// A byte with the restart flag set becomes byte zero of a new image. The
// image size register may only be written while no result is outstanding.
module ota_image_stream_deframer_top (
   input  logic                              clock,
   input  logic                              reset,
   // image bytes
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic [0:0]                        req_tuser,  // [0] start_image
   // per-byte results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] payload_byte, [23:8] element_tag, [24] header_done,
   // [40:25] header_length, [56:41] field_control, [64:57] credential_version,
   // [80:65] min_hw_version, [96:81] max_hw_version, [97] image_complete,
   // [98] overrun, [103:99] zero
   output logic [otadf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                        rsp_tuser,  // [1:0] section
   output logic                              rsp_tlast,  // element_last
   // image size register write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [31:0]                       csr_data    // image_size
);

   logic                  accept;
   logic                  free;
   logic [31:0]           image_size_ff;
   otadf_pkg::result_type result;

   assign req_tready = free;
   assign accept     = req_tvalid && free;
   assign csr_ready  = 1'b1;

   // Image size register
   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= '0;
      end else if (csr_valid) begin
         image_size_ff <= csr_data;
      end
   end

   otadf_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_tdata),
      .start_image (req_tuser[0]),
      .image_size  (image_size_ff),
      .result      (result)
   );

   otadf_outreg u_outreg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/otadf_chk.sv =====
// Port-level checker for the deframer, bound to the top level.
// Depends on otadf_pkg and ota_image_stream_deframer_top_defines.svh.
`include "ota_image_stream_deframer_top_defines.svh"

module otadf_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [otadf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                        rsp_tuser,
   input logic                              rsp_tlast
);

   otadf_pkg::rsp_data_type rsp;
   logic                    stall;
   logic                    both_flags;

   assign rsp        = rsp_tdata;
   assign stall      = rsp_tvalid && !rsp_tready;
   assign both_flags = rsp.image_complete && rsp.overrun;

   // A stalled result stays put
   `OTADF_ASSERT(a_rsp_hold, stall |=> rsp_tvalid && $stable(rsp_tdata), "stalled result moved")

   // Reset empties the result register
   `OTADF_ASSERT_ALWAYS(a_rst_empty, reset |=> !rsp_tvalid, "result valid after reset")

   // Completion and overrun exclude each other
   `OTADF_ASSERT(a_done_ovr, rsp_tvalid |-> !both_flags, "complete and overrun together")

   // Element end only inside an element header or payload
   `OTADF_ASSERT(a_last_sec, rsp_tvalid && rsp_tlast |-> rsp_tuser[1], "tlast outside an element")

   // A full register with no drain blocks the input
   `OTADF_ASSERT(a_backpr, stall |-> !req_tready, "input taken while result stalled")

endmodule

bind ota_image_stream_deframer_top otadf_chk u_otadf_chk (.*);

// ===== tb/ota_image_stream_deframer_top_tb.sv =====
// Self-checking testbench for the upgrade image stream deframer top level.
// Depends on otadf_pkg and ota_image_stream_deframer_top; drives directed runs, then random
// images, most under random stalls, and checks every result against a built-in deframer model.
module ota_image_stream_deframer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import otadf_pkg::*;

   // Directed stimulus: a run of identical bytes, optionally with hand-typed expectations for its final byte
   typedef struct packed {
      logic       st;
      logic [7:0] reps;
      logic [7:0] val;
      logic       chk;
      phase_type  sec;
      logic       last;
      logic       done;
      logic       complete;
      logic       over;
   } byte_run_type;

   localparam int DIR_RUNS = 28;
   // Image A is 87 bytes long, so completion lands on its final payload byte
   localparam logic [31:0] DIR_IMAGE_BYTES = 32'd87;

   localparam byte_run_type DIR_TABLE [DIR_RUNS] = '{
      // image A: header length 72, field control selects all three optional fields
      '{1'b1, 8'd1,  8'hFF, 1'b1, PH_MAND, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd5,  8'h00, 1'b0, PH_MAND, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd1,  8'h48, 1'b0, PH_MAND, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd1,  8'h00, 1'b0, PH_MAND, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd1,  8'h07, 1'b0, PH_MAND, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd1,  8'h00, 1'b0, PH_MAND, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd46, 8'hA5, 1'b1, PH_MAND, 1'b0, 1'b0, 1'b0, 1'b0},
      // optional header: credential, skipped destination, hw versions, extra bytes
      '{1'b0, 8'd1,  8'h5C, 1'b0, PH_OPT,  1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd8,  8'h11, 1'b0, PH_OPT,  1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd1,  8'h34, 1'b0, PH_OPT,  1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd1,  8'h12, 1'b0, PH_OPT,  1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd1,  8'h78, 1'b0, PH_OPT,  1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd1,  8'h56, 1'b0, PH_OPT,  1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd3,  8'hEE, 1'b1, PH_OPT,  1'b0, 1'b1, 1'b0, 1'b0},
      // zero-length element, tag 0xFFFF
      '{1'b0, 8'd2,  8'hFF, 1'b0, PH_EHDR, 1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd4,  8'h00, 1'b1, PH_EHDR, 1'b1, 1'b1, 1'b0, 1'b0},
      // three-byte element, ends exactly on the configured size
      '{1'b0, 8'd1,  8'h01, 1'b0, PH_EHDR, 1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd1,  8'h00, 1'b0, PH_EHDR, 1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd1,  8'h03, 1'b0, PH_EHDR, 1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd3,  8'h00, 1'b0, PH_EHDR, 1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd3,  8'h80, 1'b1, PH_PAY,  1'b1, 1'b1, 1'b1, 1'b0},
      // one byte past the size
      '{1'b0, 8'd1,  8'h00, 1'b1, PH_EHDR, 1'b0, 1'b1, 1'b0, 1'b1},
      // image B: restart mid-element, header length zero so no optional part
      '{1'b1, 8'd1,  8'h00, 1'b1, PH_MAND, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd55, 8'h00, 1'b1, PH_MAND, 1'b0, 1'b1, 1'b0, 1'b0},
      // element of maximum length, cut short by the next restart
      '{1'b0, 8'd2,  8'h00, 1'b0, PH_EHDR, 1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd4,  8'hFF, 1'b0, PH_EHDR, 1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd4,  8'h5A, 1'b1, PH_PAY,  1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b1, 8'd1,  8'hC3, 1'b1, PH_MAND, 1'b0, 1'b0, 1'b0, 1'b0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = '0;   // [7:0] data_byte
   logic [0:0]               req_tuser = '0;   // [0] start_image
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]    rsp_tdata;        // fields as in rsp_data_type, payload_byte lowest
   logic [1:0]               rsp_tuser;        // [1:0] section
   logic                     rsp_tlast;        // element_last
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [31:0]              csr_data = '0;    // image_size

   // Deframer model state
   logic [31:0] image_size_q = '0;
   phase_type   parse_phase  = PH_MAND;
   logic [31:0] byte_count   = '0;
   logic [31:0] part_offset  = '0;
   logic [15:0] hdr_len_q    = '0;
   logic [15:0] fc_q         = '0;
   logic [7:0]  cred_q       = '0;
   logic [15:0] hw_min_q     = '0;
   logic [15:0] hw_max_q     = '0;
   logic [15:0] tag_q        = '0;
   logic [31:0] elem_len_q   = '0;
   logic        hdr_done_q   = 1'b0;

   result_type  pending_results [$];
   int unsigned mismatch_count = 0;
   int unsigned bytes_sent = 0;
   bit          sender_gaps = 1'b1;
   bit          receiver_gaps = 1'b1;

   ota_image_stream_deframer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Safety net against a hung handshake
   initial begin
      #4ms;
      $display("TB_ERROR");
      $finish;
   end

   // Advance the model by one byte and return the result it should produce
   function automatic result_type deframe_byte(input logic [7:0] b, input logic st);
      result_type  r;
      phase_type   sec;
      logic        last;
      logic [32:0] nxt;
      logic [31:0] opt_len;
      logic [31:0] at;
      last = 1'b0;
      if (st) begin
         parse_phase = PH_MAND;
         byte_count  = '0;
         part_offset = '0;
         hdr_len_q   = '0;
         fc_q        = '0;
         cred_q      = '0;
         hw_min_q    = '0;
         hw_max_q    = '0;
         tag_q       = '0;
         elem_len_q  = '0;
         hdr_done_q  = 1'b0;
      end
      sec = parse_phase;
      if (byte_count != 32'hFFFF_FFFF) byte_count++;

      case (parse_phase)
         PH_MAND: begin
            case (part_offset)
               OFS_HDR_LEN_LO: hdr_len_q[7:0]  = b;
               OFS_HDR_LEN_HI: hdr_len_q[15:8] = b;
               OFS_FC_LO:      fc_q[7:0]       = b;
               OFS_FC_HI:      fc_q[15:8]      = b;
               default: ;
            endcase
            if (part_offset + 1 >= MAND_HDR_BYTES) begin
               part_offset = '0;
               if (hdr_len_q > MAND_HDR_BYTES) begin
                  parse_phase = PH_OPT;
               end else begin
                  parse_phase = PH_EHDR;
                  hdr_done_q  = 1'b1;
               end
            end else begin
               part_offset++;
            end
         end
         PH_OPT: begin
            opt_len = {16'h0, hdr_len_q} - MAND_HDR_BYTES;
            // optional fields are packed in field-control bit order
            at = '0;
            if (fc_q[FC_CRED]) begin
               if (part_offset == at) cred_q = b;
               at++;
            end
            if (fc_q[FC_DEST]) at += DEST_BYTES;
            if (fc_q[FC_HW]) begin
               if (part_offset == at)          hw_min_q[7:0]  = b;
               else if (part_offset == at + 1) hw_min_q[15:8] = b;
               else if (part_offset == at + 2) hw_max_q[7:0]  = b;
               else if (part_offset == at + 3) hw_max_q[15:8] = b;
            end
            if (part_offset + 1 >= opt_len) begin
               part_offset = '0;
               parse_phase = PH_EHDR;
               hdr_done_q  = 1'b1;
            end else begin
               part_offset++;
            end
         end
         PH_EHDR: begin
            case (part_offset)
               OFS_TAG_LO: tag_q = {8'h00, b};
               OFS_TAG_HI: tag_q[15:8] = b;
               OFS_LEN_B0: elem_len_q = {24'h0, b};
               OFS_LEN_B1: elem_len_q[15:8] = b;
               OFS_LEN_B2: elem_len_q[23:16] = b;
               OFS_LEN_B3: elem_len_q[31:24] = b;
               default: ;
            endcase
            if (part_offset + 1 >= ELEM_HDR_BYTES) begin
               part_offset = '0;
               // zero-length element ends on its own header
               if (elem_len_q == 0) last = 1'b1;
               else parse_phase = PH_PAY;
            end else begin
               part_offset++;
            end
         end
         default: begin
            nxt = {1'b0, part_offset} + 33'd1;
            if (nxt >= {1'b0, elem_len_q}) begin
               last        = 1'b1;
               part_offset = '0;
               parse_phase = PH_EHDR;
            end else begin
               part_offset = nxt[31:0];
            end
         end
      endcase

      r.section                 = sec;
      r.element_last            = last;
      r.data.pad                = '0;
      r.data.payload_byte       = b;
      r.data.element_tag        = tag_q;
      r.data.header_done        = hdr_done_q;
      r.data.header_length      = hdr_len_q;
      r.data.field_control      = fc_q;
      r.data.credential_version = cred_q;
      r.data.min_hw_version     = hw_min_q;
      r.data.max_hw_version     = hw_max_q;
      r.data.image_complete     = (image_size_q != 0) && (byte_count == image_size_q);
      r.data.overrun            = (image_size_q != 0) && (byte_count > image_size_q);
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Result side: random stalls, checked at the falling edge before the accepting edge
   always @(posedge clock) begin
      rsp_tready <= !(receiver_gaps && $urandom_range(99) < 21);
   end

   always @(negedge clock) begin
      result_type   want;
      rsp_data_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with nothing expected");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            got  = rsp_tdata;
            compare_field("section", want.section, rsp_tuser);
            compare_field("element_last", want.element_last, rsp_tlast);
            compare_field("payload_byte", want.data.payload_byte, got.payload_byte);
            compare_field("element_tag", want.data.element_tag, got.element_tag);
            compare_field("header_done", want.data.header_done, got.header_done);
            compare_field("header_length", want.data.header_length, got.header_length);
            compare_field("field_control", want.data.field_control, got.field_control);
            compare_field("credential_version", want.data.credential_version,
                          got.credential_version);
            compare_field("min_hw_version", want.data.min_hw_version, got.min_hw_version);
            compare_field("max_hw_version", want.data.max_hw_version, got.max_hw_version);
            compare_field("image_complete", want.data.image_complete, got.image_complete);
            compare_field("overrun", want.data.overrun, got.overrun);
            compare_field("pad", want.data.pad, got.pad);
         end
      end
   end

   // One image byte transaction; entered and left on a rising edge
   task automatic send_byte(input logic [7:0] b, input logic st);
      bit taken;
      taken = 1'b0;
      while (sender_gaps && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= st;
      do begin
         @(negedge clock);
         if (req_tready) begin
            taken = 1'b1;
            pending_results.push_back(deframe_byte(b, st));
         end
         @(posedge clock);
      end while (!taken);
      bytes_sent++;
   endtask

   // Drain every outstanding result with the input side quiet
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_image_size(input logic [31:0] value);
      bit taken;
      taken = 1'b0;
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(negedge clock);
         if (csr_ready) begin
            taken = 1'b1;
            image_size_q = value;
         end
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
   endtask

   // One random image: mostly well formed, sometimes preceded by noise or cut short
   task automatic send_random_image();
      logic [7:0]  img [$];
      logic [15:0] hl;
      logic [15:0] fc;
      logic [15:0] tag;
      logic [31:0] elen;
      int unsigned opt_n;
      int unsigned n_elem;
      int unsigned pick;
      int unsigned cut;
      bit          stop;
      stop = 1'b0;
      if ($urandom_range(99) < 10) begin
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)), $urandom_range(99) < 20);
      end

      pick = $urandom_range(99);
      if (pick < 55)      hl = 16'(57 + $urandom_range(24));
      else if (pick < 70) hl = 16'($urandom_range(56));
      else if (pick < 80) hl = 16'(56 + $urandom_range(1));
      else                hl = 16'($urandom_range(65535));
      fc = 16'($urandom_range(65535));

      for (int i = 0; i < MAND_HDR_BYTES; i++) begin
         case (i)
            OFS_HDR_LEN_LO: img.push_back(hl[7:0]);
            OFS_HDR_LEN_HI: img.push_back(hl[15:8]);
            OFS_FC_LO:      img.push_back(fc[7:0]);
            OFS_FC_HI:      img.push_back(fc[15:8]);
            default:        img.push_back(8'($urandom_range(255)));
         endcase
      end

      // very long optional headers are only started, then abandoned
      if (hl > MAND_HDR_BYTES) begin
         opt_n = hl - MAND_HDR_BYTES;
         if (opt_n > 80) begin
            opt_n = 20 + $urandom_range(40);
            stop  = 1'b1;
         end
         repeat (opt_n) img.push_back(8'($urandom_range(255)));
      end

      n_elem = stop ? 0 : $urandom_range(5);
      repeat (n_elem) begin
         if (!stop) begin
            tag  = 16'($urandom_range(65535));
            pick = $urandom_range(99);
            if (pick < 30)      elen = $urandom_range(2);
            else if (pick < 85) elen = $urandom_range(3, 16);
            else if (pick < 95) elen = $urandom_range(17, 40);
            else begin
               elen = $urandom();
               stop = 1'b1;
            end
            img.push_back(tag[7:0]);
            img.push_back(tag[15:8]);
            img.push_back(elen[7:0]);
            img.push_back(elen[15:8]);
            img.push_back(elen[23:16]);
            img.push_back(elen[31:24]);
            if (stop) begin
               repeat ($urandom_range(1, 6)) img.push_back(8'($urandom_range(255)));
            end else begin
               repeat (elen) img.push_back(8'($urandom_range(255)));
            end
         end
      end

      if ($urandom_range(99) < 15) cut = $urandom_range(1, img.size());
      else cut = img.size();
      for (int i = 0; i < cut; i++) send_byte(img[i], i == 0);
   endtask

   task automatic run_phase(input logic [31:0] size, input bit gaps, input int unsigned target);
      int unsigned first;
      wait_idle();
      write_image_size(size);
      sender_gaps   = gaps;
      receiver_gaps = gaps;
      first = bytes_sent;
      while (bytes_sent - first < target) send_random_image();
   endtask

   // Main sequence
   initial begin
      byte_run_type run;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_image_size(DIR_IMAGE_BYTES);
      for (int i = 0; i < DIR_RUNS; i++) begin
         run = DIR_TABLE[i];
         for (int k = 0; k < run.reps; k++) send_byte(run.val, run.st && (k == 0));
         // hand-typed values replace the model's for the run's final byte
         if (run.chk) begin
            pending_results[$].section             = run.sec;
            pending_results[$].element_last        = run.last;
            pending_results[$].data.header_done    = run.done;
            pending_results[$].data.image_complete = run.complete;
            pending_results[$].data.overrun        = run.over;
         end
      end

      // each phase overshoots its target by part of one image
      run_phase(32'd0, 1'b1, 120);
      run_phase(32'hFFFF_FFFF, 1'b0, 120);
      run_phase(32'd1, 1'b1, 120);
      run_phase($urandom_range(40, 300), 1'b1, 120);

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/otadf_pkg.sv
design/otadf_parse.sv
design/otadf_outreg.sv
design/ota_image_stream_deframer_top.sv
design/otadf_chk.sv
tb/ota_image_stream_deframer_top_tb.sv
